>>> rtl/mmfm_pkg.sv
// shared types and constants of the management frame master
`timescale 1ns / 1ps

package mmfm_pkg;

  // item operation codes
  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_START_WR = 2'd1,
    OP_START_RD = 2'd2
  } op_t;

  // frame lengths and read frame phase boundaries, in periods
  localparam logic [5:0] WRITE_PERIODS     = 6'd32;
  localparam logic [5:0] READ_PERIODS      = 6'd31;
  localparam logic [5:0] READ_DRIVEN       = 6'd14;
  localparam logic [5:0] READ_SAMPLE_FIRST = 6'd15;

  // start, op and turnaround codes
  localparam logic [3:0] HEAD_WRITE = 4'b0101;
  localparam logic [3:0] HEAD_READ  = 4'b0110;
  localparam logic [1:0] TA_WRITE   = 2'b10;

  // one input item
  typedef struct packed {
    logic [1:0]  op;
    logic [4:0]  phy_addr;
    logic [4:0]  reg_addr;
    logic [15:0] write_data;
    logic        mdi;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic        clock_pulse;
    logic        mdo;
    logic        mdo_enable;
    logic        busy_res;
    logic        done_res;
    logic [15:0] read_data;
    logic        rejected;
  } res_item_t;

  // handoff from the input register to the frame engine
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } in_stage_t;

endpackage

>>> rtl/mmfm_if.sv
// valid/ready channel interfaces for input items and result items
`timescale 1ns / 1ps

interface mmfm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [4:0]  phy_addr;
  logic [4:0]  reg_addr;
  logic [15:0] write_data;
  logic        mdi;

  modport source (output valid, op, phy_addr, reg_addr, write_data, mdi, input ready);
  modport sink (input valid, op, phy_addr, reg_addr, write_data, mdi, output ready);
endinterface

interface mmfm_out_if;
  logic        valid;
  logic        ready;
  logic        clock_pulse;
  logic        mdo;
  logic        mdo_enable;
  logic        busy_res;
  logic        done_res;
  logic [15:0] read_data;
  logic        rejected;

  modport source (output valid, clock_pulse, mdo, mdo_enable, busy_res, done_res,
                  read_data, rejected, input ready);
  modport sink (input valid, clock_pulse, mdo, mdo_enable, busy_res, done_res,
                read_data, rejected, output ready);
endinterface

>>> rtl/mmfm_in_stage.sv
// input register that captures one item per cycle while it has room
`timescale 1ns / 1ps

module mmfm_in_stage
  import mmfm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  mmfm_in_if.sink    in_ch,
  input  logic       take,
  output in_stage_t  stage
);

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;

  // room when empty or when the held item moves on this cycle
  assign in_ch.ready = !valid_r || take;
  assign valid_nxt   = in_ch.valid || (valid_r && !take);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.op         <= in_ch.op;
      item_r.phy_addr   <= in_ch.phy_addr;
      item_r.reg_addr   <= in_ch.reg_addr;
      item_r.write_data <= in_ch.write_data;
      item_r.mdi        <= in_ch.mdi;
    end
  end

  assign stage.valid = valid_r;
  assign stage.item  = item_r;

endmodule

>>> rtl/mmfm_frame_engine.sv
// frame state, per-item next-state logic and result register
`timescale 1ns / 1ps

module mmfm_frame_engine
  import mmfm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  in_stage_t  stage,
  output logic       take,
  mmfm_out_if.source out_ch
);

  logic [31:0] frame_shift_r, frame_shift_nxt;
  logic [5:0]  periods_left_r, periods_left_nxt;
  logic        read_frame_r, read_frame_nxt;
  logic [15:0] read_shift_r, read_shift_nxt;
  logic        out_valid_r;
  res_item_t   res_r, res_nxt;

  logic        busy;
  logic [5:0]  total;
  logic [5:0]  idx;

  // move the held item when the result register is free or drains
  assign take = stage.valid && (!out_valid_r || out_ch.ready);

  assign busy  = (periods_left_r != 6'd0);
  assign total = read_frame_r ? READ_PERIODS : WRITE_PERIODS;
  assign idx   = total - periods_left_r;

  // one item against the current frame state
  always_comb begin
    frame_shift_nxt  = frame_shift_r;
    periods_left_nxt = periods_left_r;
    read_frame_nxt   = read_frame_r;
    read_shift_nxt   = read_shift_r;
    res_nxt          = '0;
    unique case (stage.item.op)
      OP_START_WR, OP_START_RD: begin
        if (busy) begin
          res_nxt.rejected = 1'b1;
        end else if (stage.item.op == OP_START_WR) begin
          frame_shift_nxt  = {HEAD_WRITE, stage.item.phy_addr, stage.item.reg_addr,
                              TA_WRITE, stage.item.write_data};
          periods_left_nxt = WRITE_PERIODS;
          read_frame_nxt   = 1'b0;
          read_shift_nxt   = 16'd0;
        end else begin
          frame_shift_nxt  = {HEAD_READ, stage.item.phy_addr, stage.item.reg_addr, 18'd0};
          periods_left_nxt = READ_PERIODS;
          read_frame_nxt   = 1'b1;
          read_shift_nxt   = 16'd0;
        end
      end
      OP_TICK: begin
        if (busy) begin
          res_nxt.clock_pulse = 1'b1;
          if (!(read_frame_r && idx >= READ_DRIVEN)) begin
            res_nxt.mdo_enable = 1'b1;
            res_nxt.mdo        = frame_shift_r[31];
          end
          frame_shift_nxt = {frame_shift_r[30:0], 1'b0};
          if (read_frame_r && idx >= READ_SAMPLE_FIRST) begin
            read_shift_nxt = {read_shift_r[14:0], stage.item.mdi};
          end
          periods_left_nxt = periods_left_r - 6'd1;
          if (periods_left_nxt == 6'd0) begin
            res_nxt.done_res = 1'b1;
            if (read_frame_r) begin
              res_nxt.read_data = read_shift_nxt;
            end
          end
        end
      end
      default: begin
        // unused code leaves the frame alone
      end
    endcase
    res_nxt.busy_res = (periods_left_nxt != 6'd0);
  end

  // frame state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_shift_r  <= '0;
      periods_left_r <= '0;
      read_frame_r   <= 1'b0;
      read_shift_r   <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (take) begin
        frame_shift_r  <= frame_shift_nxt;
        periods_left_r <= periods_left_nxt;
        read_frame_r   <= read_frame_nxt;
        read_shift_r   <= read_shift_nxt;
      end
      out_valid_r <= take || (out_valid_r && !out_ch.ready);
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.clock_pulse = res_r.clock_pulse;
  assign out_ch.mdo         = res_r.mdo;
  assign out_ch.mdo_enable  = res_r.mdo_enable;
  assign out_ch.busy_res    = res_r.busy_res;
  assign out_ch.done_res    = res_r.done_res;
  assign out_ch.read_data   = res_r.read_data;
  assign out_ch.rejected    = res_r.rejected;

endmodule

>>> rtl/mdio_management_frame_master_core.sv
// top level of the preamble-free management frame master
`timescale 1ns / 1ps

// Management frame master without preamble. A start item (op 1 write, op 2 read)
// loads a frame; each later tick item (op 0) issues one management clock period
// and returns the bit driven, the drive enable and, on the read data periods,
// shifts in mdi. Write frames take 32 ticks, read frames 31; done and the read
// value come with the last period. A start while a frame runs is rejected.
// Every item gives exactly one result item. The block takes one item per clock
// while the result channel keeps up: an input register feeds the frame state
// logic, which writes a result register from which the result item leaves.
// While a result waits for out_ch.ready the input register still takes one more
// item, then in_ch.ready drops until the result item moves on.

module mdio_management_frame_master_core
  import mmfm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  mmfm_in_if.sink    in_ch,
  mmfm_out_if.source out_ch
);

  in_stage_t stage;
  logic      take;

  // input register
  mmfm_in_stage u_in_stage (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .take  (take),
    .stage (stage)
  );

  // frame logic and result register
  mmfm_frame_engine u_frame_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .stage  (stage),
    .take   (take),
    .out_ch (out_ch)
  );

endmodule
